// ===== rtl/rsb10_pkg.sv =====
// Package for the base-10 radix sorter: item types, memory entry, states and constants.
package rsb10_pkg;

  localparam int VAL_W = 31;
  localparam int BKT_W = 4;
  localparam int NUM_BKT = 11;

  // Bucket codes: "no digit left" sits below the ten digit buckets.
  localparam logic [BKT_W-1:0] BKT_NONE = 4'd0;
  localparam logic [BKT_W-1:0] BKT_LAST = 4'd10;

  // Division by ten through a reciprocal, exact for any 32-bit dividend.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             final_res;
  } res_item_t;

  // One buffer entry: the value, what is left of it above the current digit,
  // and the bucket found for it in the counting sweep.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] quot;
    logic [BKT_W-1:0] bucket;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_CNT_RD,
    S_CNT_MUL,
    S_CNT_WB,
    S_PFX,
    S_SC_RD,
    S_SC_WR,
    S_MAX_A,
    S_MAX_B,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/rsb10_div10.sv =====
// Divide-by-ten unit: registered reciprocal product, then quotient and remainder.
module rsb10_div10 (
  input  logic                      clk,
  input  logic [rsb10_pkg::VAL_W-1:0] q,
  output logic [rsb10_pkg::VAL_W-1:0] quot,
  output logic [3:0]                  rem
);
  import rsb10_pkg::*;

  localparam int PROD_W = VAL_W + 32;

  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  q_r;
  logic [VAL_W-1:0]  diff;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(q) * PROD_W'(DIV10_MAGIC);
    q_r  <= q;
  end

  assign quot = VAL_W'(prod[PROD_W-1:DIV10_SHIFT]);
  assign diff = q_r - ((quot << 3) + (quot << 1));
  assign rem  = diff[3:0];

endmodule

// ===== rtl/radix_sort_base10.sv =====
// Top level of the base-10 LSD radix sorter with ping-pong buffer memories.
//
//   channel  | ports                        | handshake
//   ---------+------------------------------+------------------------------------
//   input    | start, busy, item            | taken at an edge with start & !busy
//   result   | strobe, result               | one cycle per item, no back-pressure
//
// Loading takes one item per cycle. After the last item, each of the D passes
// (D = decimal digits of the maximum) clears the counts, counts the n held
// items (read, multiply, write back), forms the eleven bucket sums, scatters
// through the single write port of the target memory and divides the maximum.
// A check of the maximum starts the read-out; the n results follow on consecutive
// cycles through the read and result registers. Reset clears control state only.
module radix_sort_base10 #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  rsb10_pkg::in_item_t   item,
  output logic                  busy,
  output logic                  strobe,
  output rsb10_pkg::res_item_t  result
);
  import rsb10_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  state_t state, state_next;

  entry_t mem0 [MAX_ITEMS];
  entry_t mem1 [MAX_ITEMS];
  entry_t rdata0, rdata1, rdata_src;

  logic          src_we, dst_we;
  logic [AW-1:0] src_waddr, dst_waddr, rd_addr;
  entry_t        src_wdata, dst_wdata;
  logic          we0, we1;
  logic [AW-1:0] waddr0, waddr1;
  entry_t        wdata0, wdata1;

  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    last_idx;
  logic [VAL_W-1:0] maxq;
  logic             sel;
  logic [AW-1:0]    idx;
  logic [BKT_W-1:0] bidx;
  logic [CW-1:0]    run;
  logic [CW-1:0]    run_sum;
  logic [CW-1:0]    bc [NUM_BKT];
  logic             pend, pend_last;

  logic             accept, room;
  logic [VAL_W-1:0] div_in, div_quot;
  logic [3:0]       div_rem;
  logic [BKT_W-1:0] bucket_new;
  logic [CW-1:0]    pos;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign room     = (cnt < CW'(MAX_ITEMS));
  assign cnt_m1   = cnt - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];

  assign rdata_src  = sel ? rdata1 : rdata0;
  assign bucket_new = (rdata_src.quot == '0) ? BKT_NONE : (BKT_W'(div_rem) + BKT_W'(1));
  assign pos        = bc[rdata_src.bucket] - CW'(1);
  assign run_sum    = run + bc[bidx];

  rsb10_div10 u_div (
    .clk  (clk),
    .q    (div_in),
    .quot (div_quot),
    .rem  (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept && item.last) state_next = S_PASS;
      S_PASS:    state_next = (maxq == '0) ? S_EMIT : S_CNT_RD;
      S_CNT_RD:  state_next = S_CNT_MUL;
      S_CNT_MUL: state_next = S_CNT_WB;
      S_CNT_WB:  state_next = (idx == last_idx) ? S_PFX : S_CNT_RD;
      S_PFX:     if (bidx == BKT_LAST) state_next = S_SC_RD;
      S_SC_RD:   state_next = S_SC_WR;
      S_SC_WR:   state_next = (idx == '0) ? S_MAX_A : S_SC_RD;
      S_MAX_A:   state_next = S_MAX_B;
      S_MAX_B:   state_next = S_PASS;
      S_EMIT:    if (idx == last_idx) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    src_we    = 1'b0;
    src_waddr = idx;
    src_wdata = '{value: rdata_src.value, quot: div_quot, bucket: bucket_new};
    dst_we    = 1'b0;
    dst_waddr = pos[AW-1:0];
    dst_wdata = '{value: rdata_src.value, quot: rdata_src.quot, bucket: BKT_NONE};
    rd_addr   = idx;
    div_in    = rdata_src.quot;
    unique case (state)
      S_IDLE: begin
        src_we    = accept && room;
        src_waddr = cnt[AW-1:0];
        src_wdata = '{value: item.value, quot: item.value, bucket: BKT_NONE};
      end
      S_CNT_WB: src_we = 1'b1;
      S_SC_WR:  dst_we = 1'b1;
      S_MAX_A:  div_in = maxq;
      S_PASS, S_CNT_RD, S_CNT_MUL, S_PFX, S_SC_RD, S_MAX_B, S_EMIT: ;
      default: ;
    endcase
  end

  // The source buffer is mem0 when sel is low; the roles swap after every pass.
  assign we0    = sel ? dst_we : src_we;
  assign waddr0 = sel ? dst_waddr : src_waddr;
  assign wdata0 = sel ? dst_wdata : src_wdata;
  assign we1    = sel ? src_we : dst_we;
  assign waddr1 = sel ? src_waddr : dst_waddr;
  assign wdata1 = sel ? src_wdata : dst_wdata;

  always_ff @(posedge clk) begin
    if (we0) mem0[waddr0] <= wdata0;
    rdata0 <= mem0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[waddr1] <= wdata1;
    rdata1 <= mem1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      maxq      <= '0;
      sel       <= 1'b0;
      idx       <= '0;
      bidx      <= '0;
      run       <= '0;
      bc        <= '{default: '0};
      pend      <= 1'b0;
      pend_last <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= (state == S_EMIT);
      pend_last <= (state == S_EMIT) && (idx == last_idx);
      strobe    <= pend;
      case (state)
        S_IDLE: begin
          if (accept && room) begin
            cnt <= cnt + CW'(1);
            if (item.value > maxq) maxq <= item.value;
          end
        end
        S_PASS: begin
          bc   <= '{default: '0};
          idx  <= '0;
          bidx <= '0;
          run  <= '0;
        end
        S_CNT_WB: begin
          bc[bucket_new] <= bc[bucket_new] + CW'(1);
          idx            <= idx + AW'(1);
        end
        S_PFX: begin
          bc[bidx] <= run_sum;
          run      <= run_sum;
          bidx     <= bidx + BKT_W'(1);
          if (bidx == BKT_LAST) idx <= last_idx;
        end
        S_SC_WR: begin
          bc[rdata_src.bucket] <= pos;
          idx                  <= idx - AW'(1);
        end
        S_MAX_B: begin
          maxq <= div_quot;
          sel  <= ~sel;
        end
        S_EMIT: begin
          idx <= idx + AW'(1);
          if (idx == last_idx) begin
            cnt  <= '0;
            maxq <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result.sorted_value <= rdata_src.value;
    result.final_res    <= pend_last;
  end

endmodule

// ===== rtl/rsb10_check.sv =====
// Port-level checker for the radix sorter and its bind to the top level.
module rsb10_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input rsb10_pkg::in_item_t  item,
  input logic                 busy,
  input logic                 strobe,
  input rsb10_pkg::res_item_t result
);
  import rsb10_pkg::*;

  // An item that does not end the data set keeps the block open for more.
  a_load_stays_open: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last) |=> !busy)
    else $error("busy raised after an item that was not marked last");

  // The item marked last starts the sort.
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> busy)
    else $error("sort did not start after the last item");

  // Results of one run come out on consecutive cycles.
  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.final_res) |=> strobe)
    else $error("gap inside a run of results");

  // Nothing follows the final result directly.
  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.final_res) |=> !strobe)
    else $error("result right after the final one");

  // Every result comes from an emission read issued while the block was busy.
  a_result_from_sort: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy, 2))
    else $error("result without a preceding sort");

endmodule

bind radix_sort_base10 rsb10_check u_check (.*);

// ===== tb/sv/tb_radix_sort_base10.sv =====
// Self-checking testbench for the base-10 LSD radix sorter with directed and random data sets.
`timescale 1ns / 100ps

module tb_radix_sort_base10;
  import rsb10_pkg::*;

  localparam int DEPTH = 64;
  localparam int RADIX = 10;
  localparam int RANDOM_ITEMS = 130;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  logic clk = 1'b0;
  logic rst;
  logic start;
  in_item_t item;
  logic busy;
  logic strobe;
  res_item_t result;

  // Shadow copy of the data set being loaded.
  logic [VAL_W-1:0] held_vals [DEPTH];
  int unsigned held_count = 0;
  logic [VAL_W-1:0] peak_val = '0;

  res_item_t sorted_q [$];
  int unsigned mismatch_count = 0;

  radix_sort_base10 #(
    .MAX_ITEMS(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .strobe(strobe),
    .result(result)
  );

  always #10 clk = ~clk;

  // Bucket 0 holds values with no digit left at this weight; digits 0..9 go to 1..10.
  function automatic int unsigned digit_bucket(logic [VAL_W-1:0] v, longint unsigned weight);
    longint unsigned q;
    q = v / weight;
    if (q == 0) return 0;
    return 1 + int'(q % RADIX);
  endfunction

  function automatic void sort_held();
    int unsigned tally [NUM_BKT];
    logic [VAL_W-1:0] scratch [DEPTH];
    longint unsigned weight;
    int unsigned running;
    int unsigned k;
    bit more;
    weight = 1;
    more = (peak_val / weight) > 0;
    while (more) begin
      foreach (tally[b]) tally[b] = 0;
      for (int i = 0; i < held_count; i++) begin
        tally[digit_bucket(held_vals[i], weight)]++;
      end
      running = 0;
      foreach (tally[b]) begin
        running += tally[b];
        tally[b] = running;
      end
      // Walking backwards keeps each pass stable.
      for (int i = held_count; i > 0; i--) begin
        k = digit_bucket(held_vals[i-1], weight);
        tally[k]--;
        scratch[tally[k]] = held_vals[i-1];
      end
      for (int i = 0; i < held_count; i++) held_vals[i] = scratch[i];
      if (peak_val / weight < RADIX) begin
        more = 1'b0;
      end else begin
        weight *= RADIX;
      end
    end
  endfunction

  function automatic void absorb_value(in_item_t it);
    res_item_t r;
    // Items past the buffer capacity are dropped, but a last flag still ends the set.
    if (held_count < DEPTH) begin
      held_vals[held_count] = it.value;
      held_count++;
      if (it.value > peak_val) peak_val = it.value;
    end
    if (it.last) begin
      sort_held();
      for (int i = 0; i < held_count; i++) begin
        r.sorted_value = held_vals[i];
        r.final_res = (i == held_count - 1);
        sorted_q.push_back(r);
      end
      held_count = 0;
      peak_val = '0;
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Draws a value of at most cap decimal digits, with extremes and raw bit patterns mixed in.
  function automatic logic [VAL_W-1:0] pick_value(int unsigned cap);
    longint unsigned ceiling;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? VAL_MAX : '0;
    if (r == 1) return VAL_W'($urandom());
    ceiling = 1;
    repeat ($urandom_range(1, cap)) ceiling *= RADIX;
    if (ceiling > 64'h8000_0000) ceiling = 64'h8000_0000;
    return VAL_W'($urandom_range(0, 32'(ceiling - 1)));
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken, or later when a random gap follows.
  task automatic offer_value(input logic [VAL_W-1:0] v, input logic is_last, input bit steady);
    in_item_t it;
    int unsigned n;
    it.value = v;
    it.last = is_last;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_value(it);
    if (!steady) begin
      n = gap_len();
      if (n > 0) begin
        start <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  task automatic test_single_item();
    offer_value(31'd7, 1'b1, 1'b0);
  endtask

  task automatic test_zero_maximum();
    offer_value('0, 1'b1, 1'b0);
    offer_value('0, 1'b0, 1'b0);
    offer_value('0, 1'b0, 1'b0);
    offer_value('0, 1'b1, 1'b0);
  endtask

  task automatic test_extremes();
    offer_value(VAL_MAX, 1'b0, 1'b0);
    offer_value('0, 1'b0, 1'b0);
    offer_value(31'd1, 1'b0, 1'b0);
    offer_value(31'd1000000000, 1'b0, 1'b0);
    offer_value(31'd999999999, 1'b0, 1'b0);
    offer_value(VAL_MAX, 1'b1, 1'b0);
  endtask

  // Values of different lengths exercise the no-digit-left bucket.
  task automatic test_digit_mix();
    offer_value(31'd10, 1'b0, 1'b0);
    offer_value(31'd9, 1'b0, 1'b0);
    offer_value(31'd100, 1'b0, 1'b0);
    offer_value('0, 1'b0, 1'b0);
    offer_value(31'd90, 1'b0, 1'b0);
    offer_value(31'd19, 1'b0, 1'b0);
    offer_value(31'd5, 1'b1, 1'b0);
  endtask

  // Sets follow each other with no gaps, so each must start from a clean state.
  task automatic test_back_to_back();
    offer_value(31'd3, 1'b0, 1'b1);
    offer_value(31'd1, 1'b0, 1'b1);
    offer_value(31'd2, 1'b1, 1'b1);
    offer_value(31'd42, 1'b1, 1'b1);
    offer_value(31'd1000, 1'b1, 1'b1);
  endtask

  task automatic test_buffer_full();
    for (int i = 0; i < DEPTH; i++) offer_value(pick_value(10), 1'b0, 1'b0);
    offer_value(pick_value(10), 1'b0, 1'b0);
    offer_value(VAL_MAX, 1'b1, 1'b0);
  endtask

  task automatic test_random_sets();
    int unsigned size;
    int unsigned r;
    int unsigned cap;
    int unsigned sent;
    bit steady;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] prev;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        size = $urandom_range(1, 10);
      end else if (r < 95) begin
        size = $urandom_range(11, 30);
      end else begin
        size = $urandom_range(60, 67);
      end
      cap = $urandom_range(1, 10);
      steady = ($urandom_range(0, 3) == 0);
      prev = '0;
      for (int i = 0; i < size; i++) begin
        // Repeats test that equal values survive the passes.
        v = ($urandom_range(0, 4) == 0) ? prev : pick_value(cap);
        offer_value(v, i == size - 1, steady);
        prev = v;
      end
      sent += size;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_item_t want;
    if (!rst && strobe) begin
      if (sorted_q.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: value %0d final %0b",
                   result.sorted_value, result.final_res);
        end
        mismatch_count++;
      end else begin
        want = sorted_q.pop_front();
        if (result.sorted_value !== want.sorted_value ||
            result.final_res !== want.final_res) begin
          if (mismatch_count < 10) begin
            $display("result mismatch: expected value %0d final %0b, got value %0d final %0b",
                     want.sorted_value, want.final_res,
                     result.sorted_value, result.final_res);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_single_item();
    test_zero_maximum();
    test_extremes();
    test_digit_mix();
    test_back_to_back();
    test_buffer_full();
    test_random_sets();
    start <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
